/* rtl/pct_pkg.sv */
package pct_pkg;

    localparam int unsigned CHAN_W  = 8;
    localparam int unsigned COEF_W  = 16;
    localparam int unsigned PROD_W  = COEF_W + CHAN_W;
    localparam int unsigned LUM_W   = 24;
    localparam int unsigned GAIN_W  = 9;
    localparam int unsigned SCALE_W = LUM_W + GAIN_W;
    localparam int unsigned FRAC_W  = 24;

    // Luminance weights with a 16-bit fraction; they sum to exactly 1.0.
    localparam logic [COEF_W-1:0] LUMA_R = 16'd19595;
    localparam logic [COEF_W-1:0] LUMA_G = 16'd38470;
    localparam logic [COEF_W-1:0] LUMA_B = 16'd7471;

    // Channel gains in Q1.8.
    localparam logic [GAIN_W-1:0] GAIN_GREEN_RB = 9'd64;
    localparam logic [GAIN_W-1:0] GAIN_GREEN_G  = 9'd294;
    localparam logic [GAIN_W-1:0] GAIN_AMBER_R  = 9'd269;
    localparam logic [GAIN_W-1:0] GAIN_AMBER_G  = 9'd184;
    localparam logic [GAIN_W-1:0] GAIN_AMBER_B  = 9'd46;

    typedef enum logic [1:0] {
        THEME_PASS   = 2'd0,
        THEME_INVERT = 2'd1,
        THEME_GREEN  = 2'd2,
        THEME_AMBER  = 2'd3
    } t_theme;

    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] alpha;
    } t_pix;

    typedef struct packed {
        logic   valid;
        t_theme mode;
    } t_ctl;

    typedef struct packed {
        logic [GAIN_W-1:0] red;
        logic [GAIN_W-1:0] green;
        logic [GAIN_W-1:0] blue;
    } t_gain;

    function automatic t_gain theme_gain(input t_theme mode);
        t_gain g;
        g = '0;
        case (mode)
            THEME_GREEN: begin
                g.red   = GAIN_GREEN_RB;
                g.green = GAIN_GREEN_G;
                g.blue  = GAIN_GREEN_RB;
            end
            THEME_AMBER: begin
                g.red   = GAIN_AMBER_R;
                g.green = GAIN_AMBER_G;
                g.blue  = GAIN_AMBER_B;
            end
            default: begin
                g = '0;
            end
        endcase
        return g;
    endfunction

endpackage

/* rtl/pct_in_if.sv */
interface pct_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] blue_in;
    logic [7:0] green_in;
    logic [7:0] red_in;
    logic [7:0] alpha_in;

    modport source (output valid, blue_in, green_in, red_in, alpha_in, input ready);
    modport sink (input valid, blue_in, green_in, red_in, alpha_in, output ready);
endinterface

/* rtl/pct_out_if.sv */
interface pct_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] blue_out;
    logic [7:0] green_out;
    logic [7:0] red_out;
    logic [7:0] alpha_out;

    modport source (output valid, blue_out, green_out, red_out, alpha_out, input ready);
    modport sink (input valid, blue_out, green_out, red_out, alpha_out, output ready);
endinterface

/* rtl/pct_cfg_if.sv */
interface pct_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] theme;

    modport source (output valid, theme, input ready);
    modport sink (input valid, theme, output ready);
endinterface

/* rtl/pct_luma.sv */
module pct_luma (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  pct_pkg::t_ctl              i_ctl,
    input  pct_pkg::t_pix              i_pix,
    output pct_pkg::t_ctl              o_ctl,
    output pct_pkg::t_pix              o_pix,
    output logic [pct_pkg::LUM_W-1:0]  o_lum
);
    import pct_pkg::*;

    t_ctl              r_s1_ctl;
    t_pix              r_s1_pix;
    logic [PROD_W-1:0] r_prod_r;
    logic [PROD_W-1:0] r_prod_g;
    logic [PROD_W-1:0] r_prod_b;

    t_ctl              r_s2_ctl;
    t_pix              r_s2_pix;
    logic [LUM_W-1:0]  r_lum;

    logic [PROD_W+1:0] n_sum;

    // Stage 1: weight each channel.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctl <= '0;
        end else if (i_en) begin
            r_s1_ctl <= i_ctl;
        end
        if (i_en) begin
            r_s1_pix <= i_pix;
            r_prod_r <= {{CHAN_W{1'b0}}, LUMA_R} * {{COEF_W{1'b0}}, i_pix.red};
            r_prod_g <= {{CHAN_W{1'b0}}, LUMA_G} * {{COEF_W{1'b0}}, i_pix.green};
            r_prod_b <= {{CHAN_W{1'b0}}, LUMA_B} * {{COEF_W{1'b0}}, i_pix.blue};
        end
    end

    // Weights sum to 1.0, so the total never exceeds 255 << 16.
    assign n_sum = {2'b00, r_prod_r} + {2'b00, r_prod_g} + {2'b00, r_prod_b};

    // Stage 2: sum to Q8.16 luminance.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_ctl <= '0;
        end else if (i_en) begin
            r_s2_ctl <= r_s1_ctl;
        end
        if (i_en) begin
            r_s2_pix <= r_s1_pix;
            r_lum    <= n_sum[LUM_W-1:0];
        end
    end

    assign o_ctl = r_s2_ctl;
    assign o_pix = r_s2_pix;
    assign o_lum = r_lum;

endmodule

/* rtl/pct_tint.sv */
module pct_tint (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  pct_pkg::t_ctl              i_ctl,
    input  pct_pkg::t_pix              i_pix,
    input  logic [pct_pkg::LUM_W-1:0]  i_lum,
    output logic                       o_valid,
    output pct_pkg::t_pix              o_pix
);
    import pct_pkg::*;

    function automatic logic [CHAN_W-1:0] scale(input logic [LUM_W-1:0] lum,
                                                input logic [GAIN_W-1:0] gain);
        logic [SCALE_W-1:0]        prod;
        logic [SCALE_W-FRAC_W-1:0] whole;
        prod  = {{GAIN_W{1'b0}}, lum} * {{LUM_W{1'b0}}, gain};
        whole = prod[SCALE_W-1:FRAC_W];
        // Clip at full scale; only the gains above one get here.
        if (whole > {{(SCALE_W-FRAC_W-CHAN_W){1'b0}}, {CHAN_W{1'b1}}}) begin
            return {CHAN_W{1'b1}};
        end
        return whole[CHAN_W-1:0];
    endfunction

    logic  r_valid;
    t_pix  r_pix;
    t_pix  n_pix;
    t_gain w_gain;

    assign w_gain = theme_gain(i_ctl.mode);

    always_comb begin
        n_pix = i_pix;
        case (i_ctl.mode)
            THEME_INVERT: begin
                n_pix.blue  = ~i_pix.blue;
                n_pix.green = ~i_pix.green;
                n_pix.red   = ~i_pix.red;
            end
            THEME_GREEN, THEME_AMBER: begin
                n_pix.blue  = scale(i_lum, w_gain.blue);
                n_pix.green = scale(i_lum, w_gain.green);
                n_pix.red   = scale(i_lum, w_gain.red);
            end
            default: begin
                n_pix = i_pix;
            end
        endcase
    end

    // Stage 3: output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_ctl.valid;
        end
        if (i_en) begin
            r_pix <= n_pix;
        end
    end

    assign o_valid = r_valid;
    assign o_pix   = r_pix;

endmodule

/* rtl/pixel_color_theme_core.sv */
// Pixel color theme: takes one BGRA word per clock and returns it recolored by
// the theme register (0 pass-through, 1 invert, 2 green monochrome, 3 amber
// monochrome). Monochrome modes form Q8.16 luminance from 0.299R+0.587G+0.114B
// and scale it by per-channel Q1.8 gains, truncating and clipping at 255.
// Alpha passes unchanged. The datapath is three register stages (channel
// weights, luminance sum, gain scale into the output register), and while the
// output is taken the block sustains one word per clock. The stages advance
// together whenever the output register is empty or being taken, so a stalled
// output holds the whole pipe and the input ready follows that same condition.
// Write the theme only while idle; each word carries the theme that was
// current when it was accepted.
module pixel_color_theme_core (
    input  logic   i_clk,
    input  logic   i_rst_n,
    pct_in_if.sink   i_pix,
    pct_cfg_if.sink  i_cfg,
    pct_out_if.source o_pix
);
    import pct_pkg::*;

    t_theme r_theme;

    logic   w_en;
    t_ctl   w_in_ctl;
    t_pix   w_in_pix;
    t_ctl   w_luma_ctl;
    t_pix   w_luma_pix;
    logic [LUM_W-1:0] w_lum;
    logic   w_out_valid;
    t_pix   w_out_pix;

    // Theme register: always ready; the two-bit theme maps directly onto the mode select.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_theme <= THEME_PASS;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_theme <= t_theme'(i_cfg.theme);
        end
    end

    // Advance the pipe when the output register is free or drains this cycle.
    assign w_en        = !w_out_valid || o_pix.ready;
    assign i_pix.ready = w_en;

    assign w_in_ctl.valid = i_pix.valid;
    assign w_in_ctl.mode  = r_theme;
    assign w_in_pix.blue  = i_pix.blue_in;
    assign w_in_pix.green = i_pix.green_in;
    assign w_in_pix.red   = i_pix.red_in;
    assign w_in_pix.alpha = i_pix.alpha_in;

    pct_luma u_luma (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_ctl   (w_in_ctl),
        .i_pix   (w_in_pix),
        .o_ctl   (w_luma_ctl),
        .o_pix   (w_luma_pix),
        .o_lum   (w_lum)
    );

    pct_tint u_tint (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_ctl   (w_luma_ctl),
        .i_pix   (w_luma_pix),
        .i_lum   (w_lum),
        .o_valid (w_out_valid),
        .o_pix   (w_out_pix)
    );

    // Present the output register as the result word.
    assign o_pix.valid     = w_out_valid;
    assign o_pix.blue_out  = w_out_pix.blue;
    assign o_pix.green_out = w_out_pix.green;
    assign o_pix.red_out   = w_out_pix.red;
    assign o_pix.alpha_out = w_out_pix.alpha;

endmodule
